// File: hw/rtl/tcw_pkg.sv
// Shared types and constants of the text console writer.
// Holds the command record passed from the front end to the cell engine.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

    // Widths of the fixed payload fields.
    localparam int CHAR_W      = 8;
    localparam int COLOR_W     = 4;
    localparam int CELL_W      = CHAR_W + 2 * COLOR_W;
    localparam int ACTION_W    = 2;
    localparam int POS_W       = 11;
    localparam int CFG_INDEX_W = 2;

    // Action codes on the request channel.
    localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_READ  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_FOREGROUND = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BACKGROUND = 2'd1;

    // Reset colors: white on black.
    localparam logic [COLOR_W-1:0] FG_RESET = 4'd15;
    localparam logic [COLOR_W-1:0] BG_RESET = 4'd0;

    // Operations after classification.
    typedef enum logic [1:0] {
        OP_WRITE,
        OP_CLEAR,
        OP_READ,
        OP_NONE
    } op_t;

    // One classified request.
    typedef struct packed {
        op_t               op;
        logic [CELL_W-1:0] cell_word;
        logic              last;
        logic [POS_W-1:0]  addr;
    } cmd_t;

endpackage

`default_nettype wire

// File: hw/rtl/tcw_front.sv
// Front end of the text console writer: color registers, request intake
// and classification into command records. Depends on tcw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcw_front
    import tcw_pkg::*;
#(
    parameter int CELL_TOTAL = 2000
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [COLOR_W-1:0]     cfg_data,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [ACTION_W-1:0]    s_action,
    input  wire logic [CHAR_W-1:0]      s_char_code,
    input  wire logic                   s_end_of_write,
    input  wire logic [POS_W-1:0]       s_cell_address,
    input  wire logic                   init_done,
    output logic                        push_valid,
    input  wire logic                   push_ready,
    output cmd_t                        push_cmd
);

    localparam int AW = $clog2(CELL_TOTAL);
    localparam int XW = (AW > POS_W) ? AW : POS_W;

    logic [COLOR_W-1:0] fg_reg;
    logic [COLOR_W-1:0] bg_reg;
    logic               hold_valid_reg;
    cmd_t               hold_cmd_reg;
    cmd_t               cmd_next;
    logic [XW-1:0]      addr_ext;
    logic               in_range;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fg_reg <= FG_RESET;
            bg_reg <= BG_RESET;
        end else if (cfg_valid) begin
            if (cfg_index == REG_FOREGROUND) begin
                fg_reg <= cfg_data;
            end else if (cfg_index == REG_BACKGROUND) begin
                bg_reg <= cfg_data;
            end
        end
    end

    // Classify the request; a read beyond the screen becomes a no-op.
    assign addr_ext = XW'(s_cell_address);
    assign in_range = (addr_ext < XW'(CELL_TOTAL));

    always_comb begin
        cmd_next.cell_word = {bg_reg, fg_reg, s_char_code};
        cmd_next.last      = s_end_of_write;
        cmd_next.addr      = s_cell_address;
        case (s_action)
            ACT_WRITE: cmd_next.op = OP_WRITE;
            ACT_CLEAR: cmd_next.op = OP_CLEAR;
            ACT_READ:  cmd_next.op = in_range ? OP_READ : OP_NONE;
            default:   cmd_next.op = OP_NONE;
        endcase
    end

    // One holding stage in front of the queue.
    assign s_ready    = init_done && (!hold_valid_reg || push_ready);
    assign push_valid = hold_valid_reg;
    assign push_cmd   = hold_cmd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            hold_valid_reg <= 1'b1;
        end else if (push_ready) begin
            hold_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            hold_cmd_reg <= cmd_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/tcw_queue.sv
// Two-entry command queue between the front end and the cell engine.
// Depends on tcw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcw_queue
    import tcw_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire cmd_t in_cmd,
    output logic      out_valid,
    input  wire logic out_ready,
    output cmd_t      out_cmd
);

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_cmd   = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Pointer and fill count bookkeeping.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/tcw_engine.sv
// Cell engine of the text console writer: the cell memory, the cursor,
// scroll and clear sweeps, and the result register. Depends on tcw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcw_engine
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cmd_valid,
    output logic                    cmd_ready,
    input  wire cmd_t               cmd,
    output logic                    init_done,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [POS_W-1:0]        m_cursor_position,
    output logic                    m_scrolled,
    output logic                    m_write_done,
    output logic [CHAR_W-1:0]       m_read_char,
    output logic [COLOR_W-1:0]      m_read_foreground,
    output logic [COLOR_W-1:0]      m_read_background
);

    localparam int CELL_TOTAL = COLUMNS * ROWS;
    localparam int AW         = $clog2(CELL_TOTAL);
    localparam int XW         = (AW > POS_W) ? AW : POS_W;
    localparam logic [AW-1:0] LAST_CELL  = AW'(CELL_TOTAL - 1);
    localparam logic [AW-1:0] BOTTOM_ROW = AW'(CELL_TOTAL - COLUMNS);
    localparam logic [AW-1:0] LAST_SRC   = AW'(CELL_TOTAL - COLUMNS - 1);
    localparam logic [AW-1:0] ROW_STEP   = AW'(COLUMNS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_COPY,
        ST_COPY_LAST,
        ST_FILL
    } state_t;

    state_t              state_reg;
    logic [AW-1:0]       cursor_reg;
    logic [AW-1:0]       idx_reg;
    logic                copy_wv_reg;
    logic                report_reg;
    logic                pend_scrolled_reg;
    logic                pend_done_reg;
    logic                init_done_reg;
    logic                m_valid_reg;
    logic [AW-1:0]       out_cursor_reg;
    logic                out_scrolled_reg;
    logic                out_done_reg;
    logic [CELL_W-1:0]   out_cell_reg;

    logic [CELL_W-1:0]   mem [CELL_TOTAL];
    logic [CELL_W-1:0]   rdata_reg;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [CELL_W-1:0]   mem_wdata;
    logic [AW-1:0]       mem_raddr;

    logic                out_free;
    logic                take;
    logic                at_end;
    logic                out_load;
    logic [AW-1:0]       cursor_inc;
    logic [XW-1:0]       cmd_addr_ext;
    logic [XW-1:0]       out_cursor_ext;

    assign out_free     = !m_valid_reg || m_ready;
    assign cmd_ready    = (state_reg == ST_IDLE) && out_free;
    assign take         = cmd_valid && cmd_ready;
    assign at_end       = (cursor_reg == LAST_CELL);
    assign cursor_inc   = cursor_reg + AW'(1);
    assign cmd_addr_ext = XW'(cmd.addr);
    assign init_done    = init_done_reg;

    // A result is loaded this cycle: a plain write or a no-op, the end of a
    // read, or the end of a reported sweep.
    assign out_load = ((state_reg == ST_IDLE) && take &&
                       (((cmd.op == OP_WRITE) && !at_end) || (cmd.op == OP_NONE)))
                      || (state_reg == ST_READ)
                      || ((state_reg == ST_FILL) && (idx_reg == LAST_CELL) && report_reg);

    // Memory port selection for each state.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = idx_reg;
        mem_wdata = '0;
        mem_raddr = cmd_addr_ext[AW-1:0];
        case (state_reg)
            ST_IDLE: begin
                mem_we    = take && (cmd.op == OP_WRITE);
                mem_waddr = cursor_reg;
                mem_wdata = cmd.cell_word;
            end
            ST_COPY: begin
                mem_we    = copy_wv_reg;
                mem_waddr = idx_reg - AW'(1);
                mem_wdata = rdata_reg;
                mem_raddr = idx_reg + ROW_STEP;
            end
            ST_COPY_LAST: begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg - AW'(1);
                mem_wdata = rdata_reg;
            end
            ST_FILL: begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg;
                mem_wdata = '0;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Cell memory with one write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[mem_raddr];
    end

    // Sequencer, cursor and result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_FILL;
            idx_reg       <= '0;
            cursor_reg    <= '0;
            copy_wv_reg   <= 1'b0;
            report_reg    <= 1'b0;
            init_done_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            m_valid_reg <= out_load || (m_valid_reg && !m_ready);
            case (state_reg)
                ST_IDLE: begin
                    if (take) begin
                        case (cmd.op)
                            OP_WRITE: begin
                                if (at_end) begin
                                    // Last cell written: scroll up one row.
                                    cursor_reg        <= BOTTOM_ROW;
                                    idx_reg           <= '0;
                                    copy_wv_reg       <= 1'b0;
                                    report_reg        <= 1'b1;
                                    pend_scrolled_reg <= 1'b1;
                                    pend_done_reg     <= cmd.last;
                                    state_reg         <= ST_COPY;
                                end else begin
                                    cursor_reg       <= cursor_inc;
                                    out_cursor_reg   <= cursor_inc;
                                    out_scrolled_reg <= 1'b0;
                                    out_done_reg     <= cmd.last;
                                    out_cell_reg     <= '0;
                                end
                            end
                            OP_CLEAR: begin
                                cursor_reg        <= '0;
                                idx_reg           <= '0;
                                report_reg        <= 1'b1;
                                pend_scrolled_reg <= 1'b0;
                                pend_done_reg     <= 1'b0;
                                state_reg         <= ST_FILL;
                            end
                            OP_READ: begin
                                state_reg <= ST_READ;
                            end
                            default: begin
                                out_cursor_reg   <= cursor_reg;
                                out_scrolled_reg <= 1'b0;
                                out_done_reg     <= 1'b0;
                                out_cell_reg     <= '0;
                            end
                        endcase
                    end
                end
                ST_READ: begin
                    out_cursor_reg   <= cursor_reg;
                    out_scrolled_reg <= 1'b0;
                    out_done_reg     <= 1'b0;
                    out_cell_reg     <= rdata_reg;
                    state_reg        <= ST_IDLE;
                end
                ST_COPY: begin
                    // Read one row below, write it back in the cycle after.
                    copy_wv_reg <= 1'b1;
                    idx_reg     <= idx_reg + AW'(1);
                    if (idx_reg == LAST_SRC) begin
                        state_reg <= ST_COPY_LAST;
                    end
                end
                ST_COPY_LAST: begin
                    state_reg <= ST_FILL;
                end
                ST_FILL: begin
                    // Zero cells up to the end of the screen.
                    idx_reg <= idx_reg + AW'(1);
                    if (idx_reg == LAST_CELL) begin
                        state_reg     <= ST_IDLE;
                        init_done_reg <= 1'b1;
                        if (report_reg) begin
                            out_cursor_reg   <= cursor_reg;
                            out_scrolled_reg <= pend_scrolled_reg;
                            out_done_reg     <= pend_done_reg;
                            out_cell_reg     <= '0;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_cursor_ext    = XW'(out_cursor_reg);
    assign m_valid           = m_valid_reg;
    assign m_cursor_position = out_cursor_ext[POS_W-1:0];
    assign m_scrolled        = out_scrolled_reg;
    assign m_write_done      = out_done_reg;
    assign m_read_char       = out_cell_reg[CHAR_W-1:0];
    assign m_read_foreground = out_cell_reg[CHAR_W+COLOR_W-1:CHAR_W];
    assign m_read_background = out_cell_reg[CELL_W-1:CHAR_W+COLOR_W];

endmodule

`default_nettype wire

// File: hw/rtl/text_console_writer.sv
// Top level of the text console writer: front end, command queue and
// cell engine. Depends on tcw_pkg, tcw_front, tcw_queue and tcw_engine.
//
//   Channel   Direction  Handshake            Payload
//   cfg       in         cfg_valid/cfg_ready  cfg_index, cfg_data
//   s (req)   in         s_valid/s_ready      action, char, end, address
//   m (res)   out        m_valid/m_ready      cursor, flags, read cell
//
// A write or a no-op is done in the engine state that takes it, a read
// passes ST_READ too; each request also passes a holding stage and the
// queue in front of the engine. A write that fills the last cell scrolls:
// a row copy and a bottom-row clear in the cell memory. A clear, and the
// clearing pass after reset, zero every cell; during the reset pass no
// request is taken, configuration writes are. A stalled result holds the
// engine; the queue keeps taking requests until its two entries are full.
`timescale 1ns / 1ps
`default_nettype none

module text_console_writer
    import tcw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [COLOR_W-1:0]     cfg_data,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [ACTION_W-1:0]    s_action,
    input  wire logic [CHAR_W-1:0]      s_char_code,
    input  wire logic                   s_end_of_write,
    input  wire logic [POS_W-1:0]       s_cell_address,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [POS_W-1:0]            m_cursor_position,
    output logic                        m_scrolled,
    output logic                        m_write_done,
    output logic [CHAR_W-1:0]           m_read_char,
    output logic [COLOR_W-1:0]          m_read_foreground,
    output logic [COLOR_W-1:0]          m_read_background
);

    logic init_done;
    logic push_valid;
    logic push_ready;
    cmd_t push_cmd;
    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;

    // Request intake and classification.
    tcw_front #(
        .CELL_TOTAL(COLUMNS * ROWS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_char_code   (s_char_code),
        .s_end_of_write(s_end_of_write),
        .s_cell_address(s_cell_address),
        .init_done     (init_done),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_cmd      (push_cmd)
    );

    // Decoupling queue.
    tcw_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (push_valid),
        .in_ready (push_ready),
        .in_cmd   (push_cmd),
        .out_valid(cmd_valid),
        .out_ready(cmd_ready),
        .out_cmd  (cmd)
    );

    // Cell memory engine and result register.
    tcw_engine #(
        .COLUMNS(COLUMNS),
        .ROWS   (ROWS)
    ) u_engine (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd_valid        (cmd_valid),
        .cmd_ready        (cmd_ready),
        .cmd              (cmd),
        .init_done        (init_done),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_cursor_position(m_cursor_position),
        .m_scrolled       (m_scrolled),
        .m_write_done     (m_write_done),
        .m_read_char      (m_read_char),
        .m_read_foreground(m_read_foreground),
        .m_read_background(m_read_background)
    );

endmodule

`default_nettype wire

// File: sim/tb_text_console_writer.sv
// Testbench of the text console writer: a directed table, a full-screen fill
// with scrolls, then random write, read and clear traffic with color changes.
// Depends on tcw_pkg and text_console_writer.
`timescale 1ns / 1ps

module tb_text_console_writer;
    import tcw_pkg::*;

    localparam int SCREEN_COLS  = 80;
    localparam int SCREEN_ROWS  = 25;
    localparam int CELL_COUNT   = SCREEN_COLS * SCREEN_ROWS;
    localparam int ADDR_MAX     = (1 << POS_W) - 1;
    localparam int CYCLE_LIMIT  = 600_000;
    localparam int SETTLE_CYCLES = 64;
    localparam int PHASE_ITEMS  = 230;
    localparam int FILL_SCROLLS = 3;
    localparam int IDLE_PERCENT = 33;

    // Codes that the package leaves unnamed.
    localparam logic [ACTION_W-1:0]    ACT_NONE    = 2'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

    // Where a table row takes its expected result from.
    localparam logic FROM_TABLE = 1'b1;
    localparam logic FROM_MODEL = 1'b0;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [CHAR_W-1:0]   char_code;
        logic                end_of_write;
        logic [POS_W-1:0]    cell_address;
    } console_req_t;

    typedef struct packed {
        logic [POS_W-1:0]   cursor_position;
        logic               scrolled;
        logic               write_done;
        logic [CHAR_W-1:0]  read_char;
        logic [COLOR_W-1:0] read_foreground;
        logic [COLOR_W-1:0] read_background;
    } console_report_t;

    typedef struct packed {
        logic [COLOR_W-1:0] bg;
        logic [COLOR_W-1:0] fg;
        logic [CHAR_W-1:0]  code;
    } screen_cell_t;

    typedef struct packed {
        console_req_t    req;
        logic            typed;
        console_report_t report;
    } stim_row_t;

    localparam console_report_t NO_REPORT = '0;

    logic                   aclk;
    logic                   aresetn        = 1'b0;
    logic                   cfg_valid      = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index      = '0;
    logic [COLOR_W-1:0]     cfg_data       = '0;
    logic                   s_valid        = 1'b0;
    logic                   s_ready;
    logic [ACTION_W-1:0]    s_action       = '0;
    logic [CHAR_W-1:0]      s_char_code    = '0;
    logic                   s_end_of_write = 1'b0;
    logic [POS_W-1:0]       s_cell_address = '0;
    logic                   m_valid;
    logic                   m_ready        = 1'b0;
    logic [POS_W-1:0]       m_cursor_position;
    logic                   m_scrolled;
    logic                   m_write_done;
    logic [CHAR_W-1:0]      m_read_char;
    logic [COLOR_W-1:0]     m_read_foreground;
    logic [COLOR_W-1:0]     m_read_background;

    // Shadow of the console: screen contents, cursor and color registers.
    screen_cell_t      screen_cells [CELL_COUNT];
    int                shadow_cursor;
    logic [COLOR_W-1:0] text_fg;
    logic [COLOR_W-1:0] text_bg;
    int                scroll_total;

    console_report_t   pending_reports [$];
    stim_row_t         stim_table [$];
    int                error_count = 0;
    int                cycle_count = 0;
    logic              steady_flow = 1'b0;

    text_console_writer #(
        .COLUMNS(SCREEN_COLS),
        .ROWS   (SCREEN_ROWS)
    ) dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_action         (s_action),
        .s_char_code      (s_char_code),
        .s_end_of_write   (s_end_of_write),
        .s_cell_address   (s_cell_address),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_cursor_position(m_cursor_position),
        .m_scrolled       (m_scrolled),
        .m_write_done     (m_write_done),
        .m_read_char      (m_read_char),
        .m_read_foreground(m_read_foreground),
        .m_read_background(m_read_background)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    // Result side: random back-pressure, and every result checked against
    // the oldest outstanding expectation.
    always @(posedge aclk) begin
        console_report_t got;
        console_report_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                got = {m_cursor_position, m_scrolled, m_write_done, m_read_char,
                       m_read_foreground, m_read_background};
                if (pending_reports.size() == 0) begin
                    $error("unexpected result: cursor_position %0d", got.cursor_position);
                    error_count++;
                end else begin
                    want = pending_reports.pop_front();
                    check_field("cursor_position", 32'(want.cursor_position),
                                32'(got.cursor_position));
                    check_field("scrolled", 32'(want.scrolled), 32'(got.scrolled));
                    check_field("write_done", 32'(want.write_done),
                                32'(got.write_done));
                    check_field("read_char", 32'(want.read_char), 32'(got.read_char));
                    check_field("read_foreground", 32'(want.read_foreground),
                                32'(got.read_foreground));
                    check_field("read_background", 32'(want.read_background),
                                32'(got.read_background));
                end
            end
            m_ready <= steady_flow || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // Applies one request to the shadow console and returns its result.
    function automatic console_report_t console_apply(input console_req_t req);
        console_report_t rep;
        screen_cell_t    rd_cell;
        rep = '0;
        case (req.action)
            ACT_WRITE: begin
                screen_cells[shadow_cursor] = {text_bg, text_fg, req.char_code};
                shadow_cursor++;
                // Reaching the cell count scrolls everything up one row.
                if (shadow_cursor >= CELL_COUNT) begin
                    for (int k = 0; k < CELL_COUNT - SCREEN_COLS; k++)
                        screen_cells[k] = screen_cells[k + SCREEN_COLS];
                    for (int k = CELL_COUNT - SCREEN_COLS; k < CELL_COUNT; k++)
                        screen_cells[k] = '0;
                    shadow_cursor = CELL_COUNT - SCREEN_COLS;
                    rep.scrolled  = 1'b1;
                    scroll_total++;
                end
                rep.write_done = req.end_of_write;
            end
            ACT_CLEAR: begin
                foreach (screen_cells[k]) screen_cells[k] = '0;
                shadow_cursor = 0;
            end
            ACT_READ: begin
                // Addresses past the last cell read as zero.
                if (req.cell_address < CELL_COUNT) begin
                    rd_cell = screen_cells[req.cell_address];
                    rep.read_char       = rd_cell.code;
                    rep.read_foreground = rd_cell.fg;
                    rep.read_background = rd_cell.bg;
                end
            end
            default: begin
            end
        endcase
        rep.cursor_position = shadow_cursor[POS_W-1:0];
        return rep;
    endfunction

    function automatic console_req_t mk_req(input logic [ACTION_W-1:0] action,
                                            input logic [CHAR_W-1:0] code,
                                            input logic eow,
                                            input logic [POS_W-1:0] addr);
        return {action, code, eow, addr};
    endfunction

    function automatic console_report_t mk_report(input int cursor, input logic scrolled,
                                                  input logic done,
                                                  input logic [CHAR_W-1:0] rc,
                                                  input logic [COLOR_W-1:0] rf,
                                                  input logic [COLOR_W-1:0] rb);
        return {cursor[POS_W-1:0], scrolled, done, rc, rf, rb};
    endfunction

    // Mostly writes with random content, some reads, rare no-ops and clears.
    function automatic console_req_t random_request(input logic allow_clear);
        console_req_t req;
        int           pick;
        pick             = $urandom_range(99);
        req.char_code    = CHAR_W'($urandom_range(255));
        req.end_of_write = 1'($urandom_range(1));
        req.cell_address = POS_W'($urandom_range(ADDR_MAX));
        if (pick < 75)
            req.action = ACT_WRITE;
        else if (pick < 95)
            req.action = ACT_READ;
        else if (pick < 98 || !allow_clear)
            req.action = ACT_NONE;
        else
            req.action = ACT_CLEAR;
        return req;
    endfunction

    // Presents one request, with a random gap first, and records its result
    // once the request is taken.
    task automatic send_request(input console_req_t req, input logic typed,
                                input console_report_t typed_report);
        console_report_t predicted;
        if (!steady_flow && $urandom_range(99) < IDLE_PERCENT) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while (!steady_flow && $urandom_range(99) < IDLE_PERCENT);
        end
        s_valid        <= 1'b1;
        s_action       <= req.action;
        s_char_code    <= req.char_code;
        s_end_of_write <= req.end_of_write;
        s_cell_address <= req.cell_address;
        do @(posedge aclk); while (s_ready !== 1'b1);
        predicted = console_apply(req);
        pending_reports.push_back(typed ? typed_report : predicted);
    endtask

    // Holds off new requests until every outstanding result is back.
    task automatic wait_for_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_reports.size() != 0);
    endtask

    // Leaves cfg_valid high; callers lower it after their last write.
    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [COLOR_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        case (idx)
            REG_FOREGROUND: text_fg = data;
            REG_BACKGROUND: text_bg = data;
            default: begin
            end
        endcase
    endtask

    task automatic program_colors(input logic [COLOR_W-1:0] fg,
                                  input logic [COLOR_W-1:0] bg);
        write_register(REG_FOREGROUND, fg);
        write_register(REG_BACKGROUND, bg);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        // Reset, then bring the shadow console to its reset state.
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (screen_cells[k]) screen_cells[k] = '0;
        shadow_cursor = 0;
        text_fg       = FG_RESET;
        text_bg       = BG_RESET;
        scroll_total  = 0;

        // Writes to indexes past the register list must leave colors alone.
        write_register(REG_SPARE_A, 4'hF);
        write_register(REG_SPARE_B, 4'h0);
        cfg_valid <= 1'b0;

        // Directed table, run with the reset colors, white on black.
        stim_table.push_back({mk_req(ACT_READ, 8'h00, 1'b0, 11'd0), FROM_TABLE,
                              mk_report(0, 1'b0, 1'b0, 8'h00, 4'd0, 4'd0)});
        stim_table.push_back({mk_req(ACT_READ, 8'h00, 1'b0, 11'd1999), FROM_TABLE,
                              mk_report(0, 1'b0, 1'b0, 8'h00, 4'd0, 4'd0)});
        stim_table.push_back({mk_req(ACT_READ, 8'h00, 1'b0, 11'h7FF), FROM_TABLE,
                              mk_report(0, 1'b0, 1'b0, 8'h00, 4'd0, 4'd0)});
        stim_table.push_back({mk_req(ACT_NONE, 8'hFF, 1'b1, 11'h7FF), FROM_TABLE,
                              mk_report(0, 1'b0, 1'b0, 8'h00, 4'd0, 4'd0)});
        stim_table.push_back({mk_req(ACT_WRITE, 8'h00, 1'b0, 11'd0), FROM_TABLE,
                              mk_report(1, 1'b0, 1'b0, 8'h00, 4'd0, 4'd0)});
        stim_table.push_back({mk_req(ACT_WRITE, 8'hFF, 1'b1, 11'h7FF), FROM_TABLE,
                              mk_report(2, 1'b0, 1'b1, 8'h00, 4'd0, 4'd0)});
        stim_table.push_back({mk_req(ACT_READ, 8'hFF, 1'b1, 11'd0), FROM_TABLE,
                              mk_report(2, 1'b0, 1'b0, 8'h00, 4'd15, 4'd0)});
        stim_table.push_back({mk_req(ACT_READ, 8'h00, 1'b0, 11'd1), FROM_TABLE,
                              mk_report(2, 1'b0, 1'b0, 8'hFF, 4'd15, 4'd0)});
        stim_table.push_back({mk_req(ACT_READ, 8'h00, 1'b0, 11'd2), FROM_TABLE,
                              mk_report(2, 1'b0, 1'b0, 8'h00, 4'd0, 4'd0)});
        stim_table.push_back({mk_req(ACT_WRITE, 8'h80, 1'b1, 11'h400), FROM_MODEL,
                              NO_REPORT});
        stim_table.push_back({mk_req(ACT_READ, 8'h7F, 1'b0, 11'd2), FROM_MODEL,
                              NO_REPORT});
        stim_table.push_back({mk_req(ACT_NONE, 8'h55, 1'b0, 11'd2), FROM_TABLE,
                              mk_report(3, 1'b0, 1'b0, 8'h00, 4'd0, 4'd0)});
        stim_table.push_back({mk_req(ACT_CLEAR, 8'hFF, 1'b1, 11'd1), FROM_TABLE,
                              mk_report(0, 1'b0, 1'b0, 8'h00, 4'd0, 4'd0)});
        stim_table.push_back({mk_req(ACT_READ, 8'h00, 1'b0, 11'd1), FROM_TABLE,
                              mk_report(0, 1'b0, 1'b0, 8'h00, 4'd0, 4'd0)});
        stim_table.push_back({mk_req(ACT_WRITE, 8'h41, 1'b1, 11'd0), FROM_TABLE,
                              mk_report(1, 1'b0, 1'b1, 8'h00, 4'd0, 4'd0)});
        stim_table.push_back({mk_req(ACT_READ, 8'h00, 1'b0, 11'd2000), FROM_TABLE,
                              mk_report(1, 1'b0, 1'b0, 8'h00, 4'd0, 4'd0)});
        stim_table.push_back({mk_req(ACT_READ, 8'h00, 1'b0, 11'd0), FROM_TABLE,
                              mk_report(1, 1'b0, 1'b0, 8'h41, 4'd15, 4'd0)});
        foreach (stim_table[i])
            send_request(stim_table[i].req, stim_table[i].typed, stim_table[i].report);

        // Fill the whole screen and keep writing through a few scrolls,
        // with no idling on either side.
        wait_for_results();
        program_colors(4'd0, 4'd15);
        steady_flow = 1'b1;
        while (scroll_total < FILL_SCROLLS) begin
            if ($urandom_range(99) < 5)
                send_request(mk_req(ACT_READ, CHAR_W'($urandom_range(255)),
                                    1'($urandom_range(1)),
                                    POS_W'($urandom_range(ADDR_MAX))),
                             FROM_MODEL, NO_REPORT);
            else
                send_request(mk_req(ACT_WRITE, CHAR_W'($urandom_range(255)),
                                    1'($urandom_range(1)),
                                    POS_W'($urandom_range(ADDR_MAX))),
                             FROM_MODEL, NO_REPORT);
        end
        steady_flow = 1'b0;

        // Random phases, each under its own colors; clears only in the last
        // one so the earlier phases keep scrolling.
        for (int phase = 0; phase < 5; phase++) begin
            wait_for_results();
            case (phase)
                0: program_colors(4'd15, 4'd15);
                1: program_colors(4'd0, 4'd0);
                2: program_colors(FG_RESET, BG_RESET);
                default: program_colors(COLOR_W'($urandom_range(15)),
                                        COLOR_W'($urandom_range(15)));
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Once mid-phase, let the result side empty out completely.
                if (phase == 2 && n == PHASE_ITEMS / 2)
                    wait_for_results();
                send_request(random_request(phase == 4), FROM_MODEL, NO_REPORT);
            end
        end

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
